/* src/rle_pkg.sv */
// Shared types, constants and the microcode table of the run-length icon decoder.
`timescale 1ns / 1ps
package rle_pkg;

	// Display controller command bytes
	localparam logic [7:0] CMD_MEMORY_MODE  = 8'h20;
	localparam logic [7:0] CMD_COLUMN_RANGE = 8'h21;
	localparam logic [7:0] CMD_PAGE_RANGE   = 8'h22;
	localparam logic [7:0] LAST_COLUMN      = 8'h7f;

	// Run byte layout
	localparam int RUN_VALUE_IDX = 7;
	localparam int COUNT_W       = 7;

	// Sequencer program addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
	localparam logic [STEP_W-1:0] STEP_HDR  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RUN  = 4'd9;

	localparam logic [1:0] MODE_RESET = 2'd1;

	// Output byte source select
	typedef enum logic [3:0] {
		SRC_MEM_MODE,
		SRC_MODE,
		SRC_COL_CMD,
		SRC_COLUMN,
		SRC_LAST_COL,
		SRC_PAGE_CMD,
		SRC_PAGE,
		SRC_END_PAGE,
		SRC_PACK
	} src_sel_t;

	// Sequencer jump kinds
	typedef enum logic [1:0] {
		JMP_DISPATCH,  // wait for an item, branch on header
		JMP_NEXT,      // go to the next field once the step completes
		JMP_RUN        // repeat while run bits remain
	} jmp_t;

	typedef struct packed {
		src_sel_t          src;
		logic              emit;
		logic              is_data;
		logic              last;
		jmp_t              jmp;
		logic [STEP_W-1:0] next;
	} ctrl_word_t;

	// Microcode ROM
	function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '{src: SRC_PACK, emit: 1'b0, is_data: 1'b0, last: 1'b0,
			jmp: JMP_DISPATCH, next: STEP_IDLE};
		unique case (step)
			4'd0: cw = '{SRC_PACK,     1'b0, 1'b0, 1'b0, JMP_DISPATCH, STEP_IDLE};
			4'd1: cw = '{SRC_MEM_MODE, 1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd2};
			4'd2: cw = '{SRC_MODE,     1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd3};
			4'd3: cw = '{SRC_COL_CMD,  1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd4};
			4'd4: cw = '{SRC_COLUMN,   1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd5};
			4'd5: cw = '{SRC_LAST_COL, 1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd6};
			4'd6: cw = '{SRC_PAGE_CMD, 1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd7};
			4'd7: cw = '{SRC_PAGE,     1'b1, 1'b0, 1'b0, JMP_NEXT,     4'd8};
			4'd8: cw = '{SRC_END_PAGE, 1'b1, 1'b0, 1'b1, JMP_NEXT,     STEP_IDLE};
			4'd9: cw = '{SRC_PACK,     1'b1, 1'b1, 1'b0, JMP_RUN,      STEP_IDLE};
			default: cw = '{SRC_PACK,  1'b0, 1'b0, 1'b0, JMP_NEXT,     STEP_IDLE};
		endcase
		return cw;
	endfunction

endpackage

/* src/rle_if.sv */
// Valid/ready channel interfaces for code items and display byte items.
`timescale 1ns / 1ps
interface rle_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       is_header;
	logic [6:0] start_column;
	logic [2:0] start_page;

	modport source (output valid, code_byte, is_header, start_column, start_page,
		input ready);
	modport sink (input valid, code_byte, is_header, start_column, start_page,
		output ready);
endinterface

interface rle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last_of_run;

	modport source (output valid, out_byte, is_data, last_of_run, input ready);
	modport sink (input valid, out_byte, is_data, last_of_run, output ready);
endinterface

/* src/rle_icon_to_oled_stream_core.sv */
// Top level: microcoded run-length icon decoder producing an OLED command/data byte stream.
`timescale 1ns / 1ps
// One item is taken at a time. A header item takes one dispatch step plus eight
// command-byte steps; a run item takes one dispatch step plus one packing step per
// chunk of up to 8 bits. The single packing step fills the current byte and emits
// at most one data byte per cycle while the output register is free. The output byte
// sits in a register; a step that emits waits until that register is free, while a
// step that emits nothing goes on while a result waits. The mode code
// register may be written only while the block is idle.
module rle_icon_to_oled_stream_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	rle_code_if.sink          code_in,
	rle_byte_if.source        byte_out
);
	import rle_pkg::*;

	logic [STEP_W-1:0]  step_q;
	logic [1:0]         mode_q;
	logic [7:0]         partial_q;
	logic [2:0]         pos_q;
	logic               bit_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [6:0]         column_q;
	logic [2:0]         page_q;
	logic [7:0]         end_page_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_data_q;
	logic               out_last_q;

	ctrl_word_t         cw;
	logic               accept;
	logic [3:0]         room;
	logic [3:0]         take;
	logic [8:0]         fill9;
	logic [7:0]         fill;
	logic [7:0]         packed_byte;
	logic               full;
	logic [COUNT_W-1:0] cnt_after;
	logic               emit_now;
	logic               emit_last;
	logic               out_free;
	logic               advance;
	logic [7:0]         src_byte;

	// Control word of the current step
	assign cw     = ucode(step_q);
	assign accept = code_in.valid && code_in.ready;
	assign code_in.ready = (cw.jmp == JMP_DISPATCH);

	// Bit packer: fill up to the end of the current byte
	always_comb begin
		room        = 4'd8 - {1'b0, pos_q};
		take        = (cnt_q < {3'd0, room}) ? cnt_q[3:0] : room;
		fill9       = (9'd1 << take) - 9'd1;
		fill        = fill9[7:0] << pos_q;
		packed_byte = bit_q ? (partial_q | fill) : partial_q;
		full        = (({1'b0, pos_q} + take) == 4'd8);
		cnt_after   = cnt_q - {3'd0, take};
	end

	// Emit and stall control
	assign emit_now  = cw.emit && ((cw.src != SRC_PACK) || full);
	assign emit_last = cw.last || ((cw.src == SRC_PACK) && (cnt_after < 7'd8));
	assign out_free  = !out_valid_q || byte_out.ready;
	assign advance   = !emit_now || out_free;

	// Output byte mux
	always_comb begin
		unique case (cw.src)
			SRC_MEM_MODE: src_byte = CMD_MEMORY_MODE;
			SRC_MODE:     src_byte = {6'd0, mode_q};
			SRC_COL_CMD:  src_byte = CMD_COLUMN_RANGE;
			SRC_COLUMN:   src_byte = {1'b0, column_q};
			SRC_LAST_COL: src_byte = LAST_COLUMN;
			SRC_PAGE_CMD: src_byte = CMD_PAGE_RANGE;
			SRC_PAGE:     src_byte = {5'd0, page_q};
			SRC_END_PAGE: src_byte = end_page_q;
			SRC_PACK:     src_byte = packed_byte;
			default:      src_byte = packed_byte;
		endcase
	end

	// Step counter and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_IDLE;
			mode_q      <= MODE_RESET;
			partial_q   <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			unique case (cw.jmp)
				JMP_DISPATCH: begin
					if (accept) begin
						if (code_in.is_header) begin
							step_q    <= STEP_HDR;
							partial_q <= '0;
							pos_q     <= '0;
							cnt_q     <= '0;
						end else begin
							step_q <= STEP_RUN;
							cnt_q  <= code_in.code_byte[COUNT_W-1:0];
						end
					end
				end
				JMP_NEXT: begin
					if (advance) begin
						step_q <= cw.next;
					end
				end
				JMP_RUN: begin
					if (advance) begin
						cnt_q <= cnt_after;
						if (full) begin
							partial_q <= '0;
							pos_q     <= '0;
						end else begin
							partial_q <= packed_byte;
							pos_q     <= pos_q + take[2:0];
						end
						step_q <= (cnt_after != '0) ? STEP_RUN : cw.next;
					end
				end
				default: step_q <= STEP_IDLE;
			endcase
			if (emit_now && out_free) begin
				out_valid_q <= 1'b1;
			end else if (byte_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload capture and output byte register
	always_ff @(posedge clk) begin
		if (accept) begin
			bit_q      <= code_in.code_byte[RUN_VALUE_IDX];
			column_q   <= code_in.start_column;
			page_q     <= code_in.start_page;
			end_page_q <= 8'({5'd0, code_in.start_page} + {3'd0, code_in.code_byte[7:3]}
				+ 8'hff);
		end
		if (emit_now && out_free) begin
			out_byte_q <= src_byte;
			out_data_q <= cw.is_data;
			out_last_q <= emit_last;
		end
	end

	assign byte_out.valid       = out_valid_q;
	assign byte_out.out_byte    = out_byte_q;
	assign byte_out.is_data     = out_data_q;
	assign byte_out.last_of_run = out_last_q;

`ifndef SYNTHESIS
	// A header always leaves the packer empty
	a_hdr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && code_in.is_header |=> (pos_q == 3'd0) && (partial_q == 8'd0))
		else $error("packer not cleared by header");

	// The step counter stays inside the program
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_RUN)
		else $error("step counter out of program");

	// An empty run returns to dispatch after one step
	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !code_in.is_header && (code_in.code_byte[COUNT_W-1:0] == '0)
		|=> ##1 code_in.ready)
		else $error("empty run did not return to idle");

	// A byte emitted by the packing step is always flagged as pixel data
	a_pack_data: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_RUN) && emit_now && out_free |=> byte_out.valid && byte_out.is_data)
		else $error("packed byte not marked as data");
`endif

endmodule

/* dv/tb.sv */
// Self-checking testbench for the run-length icon to display byte stream decoder.
`timescale 1ns / 1ps
module tb;
	import rle_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_BYTES    = 16;

	// One expected display byte
	typedef struct packed {
		logic [7:0] out_val;
		logic       is_data;
		logic       last;
	} disp_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	rle_code_if code_if ();
	rle_byte_if byte_if ();

	rle_icon_to_oled_stream_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.code_in  (code_if),
		.byte_out (byte_if)
	);

	// Decoder state mirror
	logic [7:0] pk_byte;
	logic [2:0] pk_pos;
	logic [1:0] mode_code;

	disp_byte_t pending_bytes[$];

	bit src_idle_on;
	bit sink_idle_on;
	int sink_wait;
	int hold_left;
	int cycle_cnt;
	int n_errors;
	int n_items;
	int n_headers;
	int n_checked;
	int n_mode_writes;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d bytes still pending", $time,
				cycle_cnt, pending_bytes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic disp_byte_t mk_byte(logic [7:0] v, logic d);
		return {v, d, 1'b0};
	endfunction

	// Work out the display bytes one code item causes and queue them
	function automatic void decode_item(logic [7:0] code, logic hdr, logic [6:0] col,
		logic [2:0] page);
		disp_byte_t seq [0:MAX_BYTES-1];
		int n;
		logic [7:0] end_pg;
		logic val;
		int cnt;
		n = 0;
		if (hdr) begin
			end_pg = {5'd0, page} + {3'd0, code[7:3]} - 8'd1;
			pk_byte = 8'd0;
			pk_pos = 3'd0;
			seq[0] = mk_byte(CMD_MEMORY_MODE, 1'b0);
			seq[1] = mk_byte({6'd0, mode_code}, 1'b0);
			seq[2] = mk_byte(CMD_COLUMN_RANGE, 1'b0);
			seq[3] = mk_byte({1'b0, col}, 1'b0);
			seq[4] = mk_byte(LAST_COLUMN, 1'b0);
			seq[5] = mk_byte(CMD_PAGE_RANGE, 1'b0);
			seq[6] = mk_byte({5'd0, page}, 1'b0);
			seq[7] = mk_byte(end_pg, 1'b0);
			n = 8;
		end else begin
			val = code[RUN_VALUE_IDX];
			cnt = int'(code[6:0]);
			// pack LSB first; slots above pk_pos are always clear
			for (int j = 0; j < cnt; j++) begin
				pk_byte[pk_pos] = val;
				if (pk_pos == 3'd7) begin
					if (n < MAX_BYTES) begin
						seq[n] = mk_byte(pk_byte, 1'b1);
						n++;
					end
					pk_byte = 8'd0;
					pk_pos = 3'd0;
				end else begin
					pk_pos = pk_pos + 3'd1;
				end
			end
		end
		for (int k = 0; k < n; k++)
			pending_bytes.push_back({seq[k].out_val, seq[k].is_data, k == n - 1});
	endfunction

	// Send one code item and predict its bytes once accepted
	task automatic send_code(input logic [7:0] code, input logic hdr, input logic [6:0] col,
		input logic [2:0] page);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			code_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		code_if.valid        = 1'b1;
		code_if.code_byte    = code;
		code_if.is_header    = hdr;
		code_if.start_column = col;
		code_if.start_page   = page;
		do @(posedge clk); while (!code_if.ready);
		decode_item(code, hdr, col, page);
		n_items++;
		if (hdr)
			n_headers++;
	endtask

	// Stop sending and let every expected byte arrive, plus the tail of a short run
	task automatic wait_idle();
		@(negedge clk);
		code_if.valid = 1'b0;
		while (pending_bytes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		wait_idle();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we    = 1'b0;
		mode_code = m;
		n_mode_writes++;
	endtask

	// Run byte with mostly short counts
	function automatic logic [7:0] rand_run();
		int sel;
		logic [6:0] cnt;
		logic v;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			cnt = 7'($urandom_range(0, 15));
		else if (sel < 9)
			cnt = 7'($urandom_range(16, 63));
		else
			cnt = 7'($urandom_range(64, 127));
		v = 1'($urandom_range(0, 1));
		return {v, cnt};
	endfunction

	task automatic send_run(input logic [7:0] code);
		send_code(code, 1'b0, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
	endtask

	task automatic send_rand_header();
		send_code(8'($urandom_range(0, 255)), 1'b1, 7'($urandom_range(0, 127)),
			3'($urandom_range(0, 7)));
	endtask

	// Receiver: long hold-off first, then the per-item wait
	initial begin
		byte_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				byte_if.ready = 1'b0;
				hold_left--;
			end else if (sink_wait > 0) begin
				byte_if.ready = 1'b0;
				sink_wait--;
			end else begin
				byte_if.ready = 1'b1;
			end
		end
	end

	// Compare each accepted byte with the oldest expectation
	always @(posedge clk) begin : check_bytes
		disp_byte_t want;
		if (arst_n && byte_if.valid && byte_if.ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h (is_data %b last %b)", $time,
					byte_if.out_byte, byte_if.is_data, byte_if.last_of_run);
				n_errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (byte_if.out_byte !== want.out_val) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.out_val,
						byte_if.out_byte);
					n_errors++;
				end
				if (byte_if.is_data !== want.is_data) begin
					$display("%0t: is_data expected %b actual %b", $time, want.is_data,
						byte_if.is_data);
					n_errors++;
				end
				if (byte_if.last_of_run !== want.last) begin
					$display("%0t: last_of_run expected %b actual %b", $time, want.last,
						byte_if.last_of_run);
					n_errors++;
				end
			end
			n_checked++;
			sink_wait = sink_idle_on ? $urandom_range(0, 6) : 0;
		end
	end

	// Runs are packed even before the first header
	task automatic test_runs_before_header();
		send_run(8'h85);
		send_run(8'h03);
		send_run(8'h80);
		send_run(8'hff);
		send_run(8'h01);
	endtask

	// Header field extremes, short icons and a dropped partial byte
	task automatic test_header_fields();
		send_code(8'd0, 1'b1, 7'd0, 3'd0);
		send_code(8'd255, 1'b1, 7'd127, 3'd7);
		send_code(8'd7, 1'b1, 7'h55, 3'd5);
		send_code(8'd64, 1'b1, 7'h2a, 3'd2);
		send_run(8'h83);
		send_code(8'd16, 1'b1, 7'd3, 3'd1);
		send_run(8'h88);
	endtask

	// Longest runs, empty runs and byte boundary crossings
	task automatic test_run_lengths();
		send_run(8'h7f);
		send_run(8'hff);
		send_run(8'h00);
		send_run(8'h01);
		send_run(8'h87);
		send_run(8'h08);
		send_run(8'h8f);
	endtask

	// Every mode code value, including the unused one
	task automatic test_mode_codes();
		write_mode(2'd0);
		send_rand_header();
		write_mode(2'd2);
		send_rand_header();
		write_mode(2'd3);
		send_rand_header();
		write_mode(MODE_RESET);
	endtask

	// Mostly well-formed icons with random content, some noise in between
	task automatic test_random_icons();
		int done_cnt;
		int next_cfg;
		logic [7:0] c;
		logic h;
		done_cnt = 0;
		next_cfg = 35;
		while (done_cnt < 55) begin
			if ($urandom_range(0, 9) < 8) begin
				send_rand_header();
				done_cnt++;
				repeat ($urandom_range(1, 8)) begin
					c = rand_run();
					send_run(c);
					if (c[6:0] != 7'd0)
						done_cnt++;
				end
			end else begin
				repeat ($urandom_range(1, 3)) begin
					c = 8'($urandom_range(0, 255));
					h = 1'($urandom_range(0, 1));
					send_code(c, h, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
					if (h || c[6:0] != 7'd0)
						done_cnt++;
				end
			end
			if (done_cnt >= next_cfg) begin
				write_mode(2'($urandom_range(0, 3)));
				next_cfg += 35;
			end
		end
	endtask

	// Full rate on both sides
	task automatic test_back_to_back();
		wait_idle();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_rand_header();
		repeat (20) send_run(rand_run());
		wait_idle();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	// Receiver holds off long enough for the decoder to stall its input
	task automatic test_output_stall();
		hold_left = 150;
		send_rand_header();
		repeat (8) send_run({$urandom_range(0, 1) == 1, 7'($urandom_range(64, 127))});
		wait_idle();
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = MODE_RESET;
		code_if.valid        = 1'b0;
		code_if.code_byte    = 8'd0;
		code_if.is_header    = 1'b0;
		code_if.start_column = 7'd0;
		code_if.start_page   = 3'd0;
		src_idle_on          = 1'b1;
		sink_idle_on         = 1'b1;
		sink_wait            = 0;
		hold_left            = 0;
		n_errors             = 0;
		n_items              = 0;
		n_headers            = 0;
		n_checked            = 0;
		n_mode_writes        = 0;
		pk_byte              = 8'd0;
		pk_pos               = 3'd0;
		mode_code            = MODE_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_runs_before_header();
		test_header_fields();
		test_run_lengths();
		test_mode_codes();
		test_random_icons();
		test_back_to_back();
		test_output_stall();
		wait_idle();

		$display("Sent %0d code items (%0d headers), checked %0d display bytes, %0d mode writes",
			n_items, n_headers, n_checked, n_mode_writes);
		$display("Covered directed edge cases, random icons, full-rate traffic and output stall");
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
